// File: rtl/lppe_pkg.sv
package lppe_pkg;

   // widths of the frame counters and the fixed point fraction
   localparam int FRAME_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int POS_BITS      = FRAME_BITS + FRACTION_BITS;
   localparam int RATIO_BITS    = 8 + FRACTION_BITS;
   localparam int PROD_BITS     = FRAME_BITS + RATIO_BITS;
   localparam int SUM_BITS      = PROD_BITS + 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int DIV_CNT_BITS  = $clog2(POS_BITS + 1);

   // operation codes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_LOOP    = 2'd1;
   localparam logic [1:0] OP_REQUEST = 2'd2;
   localparam logic [1:0] OP_ADVANCE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_LEN  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOP_EN  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXPLICIT = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST    = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAST     = 3'd7;

   // ratio value 1.0
   localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRACTION_BITS;

   typedef struct packed {
      logic [1:0]            operation;
      logic [POS_BITS-1:0]   start_position;
      logic [FRAME_BITS-1:0] frame_count;
   } req_payload_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] granted_frames;
      logic                  end_reached;
      logic                  loop_active;
      logic                  wrapped_flag;
      logic [FRAME_BITS-1:0] output_position;
      logic [POS_BITS-1:0]   source_position;
   } rsp_payload_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_START_DIV,
      CMD_START_DONE,
      CMD_LOOP_SETUP,
      CMD_DIV_FIRST,
      CMD_DIV_LAST,
      CMD_LOOP_FINISH,
      CMD_REQUEST,
      CMD_ADV_ADD,
      CMD_ADV_MUL,
      CMD_ADV_SUM,
      CMD_ADV_WRAP,
      CMD_RESP_LOAD
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       loop_go;
      logic       div_done;
      logic       rsp_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_START_WAIT,
      ST_LOOP_CHECK,
      ST_LOOP_WAIT0,
      ST_LOOP_WAIT1,
      ST_ADV_MUL,
      ST_ADV_SUM,
      ST_ADV_WRAP,
      ST_RESP
   } ctrl_state_type;

endpackage

// File: rtl/lppe_div.sv
module lppe_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lppe_pkg::POS_BITS-1:0]       dividend,
   input  logic [lppe_pkg::RATIO_BITS-1:0]     divisor,
   output logic                                done,
   output logic [lppe_pkg::POS_BITS-1:0]       quotient
);

   localparam int Dw = lppe_pkg::POS_BITS;
   localparam int Vw = lppe_pkg::RATIO_BITS;
   localparam int Cw = lppe_pkg::DIV_CNT_BITS;

   logic [Dw-1:0] dvd_ff, dvd_in;
   logic [Vw-1:0] rem_ff, rem_in;
   logic [Vw-1:0] dvs_ff, dvs_in;
   logic [Cw-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [Vw:0]   rem_sh;
   logic [Vw:0]   rem_sub;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[Dw-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = Cw'(Dw);
      end else if (cnt_ff != '0) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[Vw-1:0];
            dvd_in = {dvd_ff[Dw-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[Vw-1:0];
            dvd_in = {dvd_ff[Dw-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - Cw'(1);
         done_in = (cnt_ff == Cw'(1));
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: rtl/lppe_dp.sv
module lppe_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lppe_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lppe_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  lppe_pkg::req_payload_type           req_payload,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output lppe_pkg::rsp_payload_type           rsp_payload,
   input  lppe_pkg::dp_cmd_type                cmd,
   output lppe_pkg::dp_status_type             status
);

   localparam int Fw   = lppe_pkg::FRAME_BITS;
   localparam int Frac = lppe_pkg::FRACTION_BITS;
   localparam int Pw   = lppe_pkg::POS_BITS;
   localparam int Rw   = lppe_pkg::RATIO_BITS;
   localparam int Mw   = lppe_pkg::PROD_BITS;
   localparam int Sw   = lppe_pkg::SUM_BITS;

   // configuration registers
   logic [Fw-1:0] total_ff, olen_ff, base_ff, rfirst_ff, rlast_ff;
   logic [Rw-1:0] ratio_ff;
   logic          loop_en_ff, explicit_ff;

   // latched input word
   logic [1:0]    op_ff;
   logic [Pw-1:0] start_ff;
   logic [Fw-1:0] count_ff;

   // playback state
   logic [Pw-1:0] src_ff, src_in;
   logic [Fw-1:0] out_ff, out_in;
   logic          valid_ff, valid_in, armed_ff, armed_in, wrapped_ff, wrapped_in;
   logic [Fw-1:0] lsb0_ff, lsb0_in, lsb1_ff, lsb1_in, lob0_ff, lob0_in, lob1_ff, lob1_in;
   logic          loop_go_ff, loop_go_in;
   logic [Fw-1:0] grant_ff, grant_in;
   logic [Mw-1:0] prod_ff, prod_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lppe_pkg::rsp_payload_type rsp_ff, rsp_in;

   // derived values
   logic [Rw-1:0] eratio;
   logic [Fw-1:0] ebase;
   logic [Pw-1:0] base_fx, total_fx, pos_clamp;
   logic [Fw-1:0] first_raw, last_raw, first_c, last_c, rg_lo, rg_hi;
   logic          region_in;
   logic [Pw-1:0] div_sel, div_dividend, quotient;
   logic          div_start, div_done;
   logic [Fw-1:0] q_sat;
   logic [Pw-1:0] first_fx, last_fx;
   logic          ob_valid, arm_n, wr_n;
   logic [Fw:0]   adv_sum;
   logic [Sw-1:0] src_sum;
   logic [Fw-1:0] rem;

   always_comb begin
      eratio    = (ratio_ff == '0) ? lppe_pkg::RATIO_ONE : ratio_ff;
      ebase     = (base_ff > total_ff) ? total_ff : base_ff;
      base_fx   = {ebase, Frac'(0)};
      total_fx  = {total_ff, Frac'(0)};
      pos_clamp = (start_ff > total_fx) ? total_fx : start_ff;
      first_fx  = {lsb0_ff, Frac'(0)};
      last_fx   = {lsb1_ff, Frac'(0)};
      // effective loop region, clamped and ordered
      first_raw = explicit_ff ? rfirst_ff : '0;
      last_raw  = explicit_ff ? rlast_ff : total_ff;
      first_c   = (first_raw > total_ff) ? total_ff : first_raw;
      last_c    = (last_raw > total_ff) ? total_ff : last_raw;
      rg_lo     = (first_c > last_c) ? last_c : first_c;
      rg_hi     = (first_c > last_c) ? first_c : last_c;
      region_in = loop_en_ff && (total_ff != '0) && (rg_hi > rg_lo);
      // divider operand select, offset from the base frame
      unique case (cmd)
         lppe_pkg::CMD_START_DIV: div_sel = pos_clamp;
         lppe_pkg::CMD_DIV_FIRST: div_sel = first_fx;
         default:                 div_sel = last_fx;
      endcase
      div_dividend = (div_sel > base_fx) ? (div_sel - base_fx) : '0;
      div_start    = (cmd == lppe_pkg::CMD_START_DIV) || (cmd == lppe_pkg::CMD_DIV_FIRST)
                     || (cmd == lppe_pkg::CMD_DIV_LAST);
      q_sat        = (quotient > Pw'(olen_ff)) ? olen_ff : quotient[Fw-1:0];
   end

   lppe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (eratio),
      .done     (div_done),
      .quotient (quotient)
   );

   // state updates per command
   always_comb begin
      src_in       = src_ff;
      out_in       = out_ff;
      valid_in     = valid_ff;
      armed_in     = armed_ff;
      wrapped_in   = wrapped_ff;
      lsb0_in      = lsb0_ff;
      lsb1_in      = lsb1_ff;
      lob0_in      = lob0_ff;
      lob1_in      = lob1_ff;
      loop_go_in   = loop_go_ff;
      grant_in     = grant_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ob_valid     = q_sat > lob0_ff;
      arm_n        = 1'b0;
      wr_n         = wrapped_ff;
      adv_sum      = {1'b0, out_ff} + {1'b0, count_ff};
      src_sum      = Sw'(base_fx) + Sw'(prod_ff);
      rem          = '0;
      unique case (cmd)
         lppe_pkg::CMD_NONE: begin
         end
         lppe_pkg::CMD_CAPTURE: begin
            grant_in = '0;
         end
         lppe_pkg::CMD_START_DIV: begin
         end
         lppe_pkg::CMD_START_DONE: begin
            src_in     = pos_clamp;
            out_in     = q_sat;
            valid_in   = 1'b0;
            armed_in   = 1'b0;
            wrapped_in = 1'b0;
            lsb0_in    = '0;
            lsb1_in    = '0;
            lob0_in    = '0;
            lob1_in    = '0;
         end
         lppe_pkg::CMD_LOOP_SETUP: begin
            valid_in   = 1'b0;
            lob0_in    = '0;
            lob1_in    = '0;
            lsb0_in    = region_in ? rg_lo : '0;
            lsb1_in    = region_in ? rg_hi : '0;
            loop_go_in = region_in && (rg_lo >= ebase);
            if (!(region_in && (rg_lo >= ebase))) begin
               armed_in   = 1'b0;
               wrapped_in = 1'b0;
            end
         end
         lppe_pkg::CMD_DIV_FIRST: begin
         end
         lppe_pkg::CMD_DIV_LAST: begin
            lob0_in = q_sat;
         end
         lppe_pkg::CMD_LOOP_FINISH: begin
            lob1_in  = q_sat;
            valid_in = ob_valid;
            if (!ob_valid) begin
               armed_in   = 1'b0;
               wrapped_in = 1'b0;
            end else begin
               arm_n = armed_ff || (src_ff < last_fx);
               if (!armed_ff && !(src_ff < last_fx)) wr_n = 1'b0;
               armed_in   = arm_n;
               wrapped_in = wr_n;
               if (arm_n && ((src_ff >= last_fx) || (out_ff >= q_sat))) begin
                  src_in     = first_fx;
                  out_in     = lob0_ff;
                  wrapped_in = 1'b1;
               end
            end
         end
         lppe_pkg::CMD_REQUEST: begin
            grant_in = '0;
            if (count_ff != '0) begin
               if (valid_ff && armed_ff) begin
                  if (out_ff >= lob1_ff) begin
                     src_in = last_fx;
                  end else begin
                     rem      = lob1_ff - out_ff;
                     grant_in = (count_ff < rem) ? count_ff : rem;
                  end
               end else if (out_ff < olen_ff) begin
                  rem      = olen_ff - out_ff;
                  grant_in = (count_ff < rem) ? count_ff : rem;
               end
            end
         end
         lppe_pkg::CMD_ADV_ADD: begin
            out_in = (adv_sum > {1'b0, olen_ff}) ? olen_ff : adv_sum[Fw-1:0];
         end
         lppe_pkg::CMD_ADV_MUL: begin
            prod_in = Mw'(out_ff) * Mw'(eratio);
         end
         lppe_pkg::CMD_ADV_SUM: begin
            src_in = (src_sum > Sw'(total_fx)) ? total_fx : src_sum[Pw-1:0];
         end
         lppe_pkg::CMD_ADV_WRAP: begin
            if (valid_ff && armed_ff && (src_ff >= last_fx)) begin
               src_in     = first_fx;
               out_in     = lob0_ff;
               wrapped_in = 1'b1;
            end
         end
         lppe_pkg::CMD_RESP_LOAD: begin
            rsp_valid_in           = 1'b1;
            rsp_in.granted_frames  = grant_ff;
            rsp_in.end_reached     = !(valid_ff && armed_ff) && (out_ff >= olen_ff);
            rsp_in.loop_active     = valid_ff && armed_ff;
            rsp_in.wrapped_flag    = wrapped_ff;
            rsp_in.output_position = out_ff;
            rsp_in.source_position = src_ff;
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         olen_ff     <= '0;
         ratio_ff    <= lppe_pkg::RATIO_ONE;
         base_ff     <= '0;
         loop_en_ff  <= 1'b0;
         explicit_ff <= 1'b0;
         rfirst_ff   <= '0;
         rlast_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lppe_pkg::CSR_TOTAL:    total_ff    <= csr_write_data[Fw-1:0];
            lppe_pkg::CSR_OUT_LEN:  olen_ff     <= csr_write_data[Fw-1:0];
            lppe_pkg::CSR_RATIO:    ratio_ff    <= csr_write_data[Rw-1:0];
            lppe_pkg::CSR_BASE:     base_ff     <= csr_write_data[Fw-1:0];
            lppe_pkg::CSR_LOOP_EN:  loop_en_ff  <= csr_write_data[0];
            lppe_pkg::CSR_EXPLICIT: explicit_ff <= csr_write_data[0];
            lppe_pkg::CSR_FIRST:    rfirst_ff   <= csr_write_data[Fw-1:0];
            lppe_pkg::CSR_LAST:     rlast_ff    <= csr_write_data[Fw-1:0];
            default: begin
            end
         endcase
      end
   end

   // input word latch and payload registers
   always_ff @(posedge clock) begin
      if (cmd == lppe_pkg::CMD_CAPTURE) begin
         op_ff    <= req_payload.operation;
         start_ff <= req_payload.start_position;
         count_ff <= req_payload.frame_count;
      end
      prod_ff  <= prod_in;
      grant_ff <= grant_in;
      rsp_ff   <= rsp_in;
   end

   // playback state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff       <= '0;
         out_ff       <= '0;
         valid_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         wrapped_ff   <= 1'b0;
         lsb0_ff      <= '0;
         lsb1_ff      <= '0;
         lob0_ff      <= '0;
         lob1_ff      <= '0;
         loop_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_ff       <= src_in;
         out_ff       <= out_in;
         valid_ff     <= valid_in;
         armed_ff     <= armed_in;
         wrapped_ff   <= wrapped_in;
         lsb0_ff      <= lsb0_in;
         lsb1_ff      <= lsb1_in;
         lob0_ff      <= lob0_in;
         lob1_ff      <= lob1_in;
         loop_go_ff   <= loop_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.op         = op_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.loop_go    = loop_go_ff;
   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;

endmodule

// File: rtl/lppe_ctrl.sv
module lppe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lppe_pkg::dp_status_type status,
   output lppe_pkg::dp_cmd_type    cmd
);

   lppe_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lppe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencing of one operation
   always_comb begin
      state_in  = state_ff;
      cmd       = lppe_pkg::CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         lppe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = lppe_pkg::CMD_CAPTURE;
               state_in = lppe_pkg::ST_DISPATCH;
            end
         end
         lppe_pkg::ST_DISPATCH: begin
            unique case (status.op)
               lppe_pkg::OP_START: begin
                  cmd      = lppe_pkg::CMD_START_DIV;
                  state_in = lppe_pkg::ST_START_WAIT;
               end
               lppe_pkg::OP_LOOP: begin
                  cmd      = lppe_pkg::CMD_LOOP_SETUP;
                  state_in = lppe_pkg::ST_LOOP_CHECK;
               end
               lppe_pkg::OP_REQUEST: begin
                  cmd      = lppe_pkg::CMD_REQUEST;
                  state_in = lppe_pkg::ST_RESP;
               end
               default: begin
                  if (status.count_zero) begin
                     state_in = lppe_pkg::ST_RESP;
                  end else begin
                     cmd      = lppe_pkg::CMD_ADV_ADD;
                     state_in = lppe_pkg::ST_ADV_MUL;
                  end
               end
            endcase
         end
         lppe_pkg::ST_START_WAIT: begin
            if (status.div_done) begin
               cmd      = lppe_pkg::CMD_START_DONE;
               state_in = lppe_pkg::ST_RESP;
            end
         end
         lppe_pkg::ST_LOOP_CHECK: begin
            if (status.loop_go) begin
               cmd      = lppe_pkg::CMD_DIV_FIRST;
               state_in = lppe_pkg::ST_LOOP_WAIT0;
            end else begin
               state_in = lppe_pkg::ST_RESP;
            end
         end
         lppe_pkg::ST_LOOP_WAIT0: begin
            if (status.div_done) begin
               cmd      = lppe_pkg::CMD_DIV_LAST;
               state_in = lppe_pkg::ST_LOOP_WAIT1;
            end
         end
         lppe_pkg::ST_LOOP_WAIT1: begin
            if (status.div_done) begin
               cmd      = lppe_pkg::CMD_LOOP_FINISH;
               state_in = lppe_pkg::ST_RESP;
            end
         end
         lppe_pkg::ST_ADV_MUL: begin
            cmd      = lppe_pkg::CMD_ADV_MUL;
            state_in = lppe_pkg::ST_ADV_SUM;
         end
         lppe_pkg::ST_ADV_SUM: begin
            cmd      = lppe_pkg::CMD_ADV_SUM;
            state_in = lppe_pkg::ST_ADV_WRAP;
         end
         lppe_pkg::ST_ADV_WRAP: begin
            cmd      = lppe_pkg::CMD_ADV_WRAP;
            state_in = lppe_pkg::ST_RESP;
         end
         lppe_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               cmd      = lppe_pkg::CMD_RESP_LOAD;
               state_in = lppe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lppe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/looped_playback_position_engine.sv
// Playback position engine for looped playback of a rendered take.
// Input channel req_*: one word carries an operation (start, update loop,
// request frames, advance by written frames), a Q32.16 start frame and a
// frame count. Result channel rsp_*: exactly one word per input word with
// the grant, end and loop flags and both cursors after the operation.
// Configuration port csr_*: register writes take effect at once; write only
// while no operation is in flight.
// Start and an update loop that sets up a loop use the shared restoring
// divider, the loop update once for the first and once for the last frame;
// a request, an advance and an update loop with no loop use no divider. One
// operation is in flight at a time: a new input word is taken only once the
// last result has been loaded into the output register.
// Reset (synchronous, active high) clears cursors, loop state and the result
// valid flag and loads the register defaults (ratio 1.0, all others zero).
// When the receiver stalls the result is held in the output register; the
// block still takes the next word and finishes it, then waits to deliver.
module looped_playback_position_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lppe_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lppe_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [lppe_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lppe_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   lppe_pkg::dp_cmd_type    cmd;
   lppe_pkg::dp_status_type status;

   lppe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lppe_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: rtl/lppe_checker.sv
module lppe_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  lppe_pkg::rsp_payload_type rsp_payload
);

   // a held result word stays put
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result word changed while stalled");

   // nothing to deliver right after reset
   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   // end of playback and an active loop exclude each other
   property p_end_vs_loop;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> !(rsp_payload.end_reached && rsp_payload.loop_active);
   endproperty
   a_end_vs_loop: assert property (p_end_vs_loop) else $error("end reached with active loop");

   // no frames granted at the end of playback
   property p_end_no_grant;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_payload.end_reached |-> rsp_payload.granted_frames == '0;
   endproperty
   a_end_no_grant: assert property (p_end_no_grant) else $error("grant at end of playback");

endmodule

bind looped_playback_position_engine lppe_checker u_lppe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
